[design/pse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, token codes and command/status definitions for the postfix
// stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int WORD_W            = 48;
    localparam int TOKEN_W           = 8;
    localparam int STATUS_W          = 3;
    localparam int PROD_W            = 2 * WORD_W;
    localparam int HALF_W            = WORD_W / 2;
    localparam int DEF_STACK_DEPTH   = 64;
    localparam int DEF_FRACTION_BITS = 16;

    localparam logic [TOKEN_W-1:0] TOK_END  = 8'h00;
    localparam logic [TOKEN_W-1:0] TOK_ADD  = 8'h2B;
    localparam logic [TOKEN_W-1:0] TOK_SUB  = 8'h2D;
    localparam logic [TOKEN_W-1:0] TOK_MUL  = 8'h2A;
    localparam logic [TOKEN_W-1:0] TOK_DIV  = 8'h2F;
    localparam logic [TOKEN_W-1:0] TOK_ZERO = 8'h30;
    localparam logic [TOKEN_W-1:0] TOK_NINE = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_FULL  = 3'd2,
        ST_DIV0  = 3'd3,
        ST_EMPTY = 3'd4,
        ST_SAT   = 3'd5
    } status_code_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_PUSH,
        CMD_FLAG_UNDER,
        CMD_FLAG_FULL,
        CMD_RD_LOWER,
        CMD_RD_TOP,
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_START,
        CMD_STEP,
        CMD_WRITE,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic is_end;
        logic is_op;
        op_t  op;
        logic lt2;
        logic full;
        logic count_zero;
        logic b_zero;
        logic iter_done;
    } dp_status_t;

    function automatic op_t op_of(input logic [TOKEN_W-1:0] t);
        op_t o;
        case (t)
            TOK_SUB: o = OP_SUB;
            TOK_MUL: o = OP_MUL;
            TOK_DIV: o = OP_DIV;
            default: o = OP_ADD;
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

[design/postfix_stack_evaluator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core
// Reverse Polish expression evaluator on a 48-bit signed fixed-point stack.
// ----------------------------------------------------------------------------
// One token byte is taken per item. A digit pushes its value, any other
// non-operator byte pushes zero, the operators + - * / combine the two top
// entries as (deeper op top), and the zero byte returns the stack top and the
// sticky status as one result item, then empties the stack. Items are handled
// one at a time by a sequencer over a single-port stack memory: a push, or
// an operator with too few operands, ends at decode; an operator otherwise
// reads both entries and writes the result back, * summing four 24x24
// partial products in turn and / taking one quotient bit per cycle from the
// restoring divider (none when the divisor is zero). A result waits in
// the output register while the next items are already being taken; only a
// second end byte stalls until the first result has been taken.
module postfix_stack_evaluator_core #(
    parameter int STACK_DEPTH   = pse_pkg::DEF_STACK_DEPTH,
    parameter int FRACTION_BITS = pse_pkg::DEF_FRACTION_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] token
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // [47:0] answer, [50:48] status, rest zero
);

    pse_pkg::cmd_t       cmd;
    pse_pkg::dp_status_t stat;
    logic [pse_pkg::WORD_W-1:0]   answer;
    logic [pse_pkg::STATUS_W-1:0] status;

    // The sequencer decides what happens each cycle.
    pse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the stack, the arithmetic units and the result.
    pse_dpath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_token (s_tdata),
        .stat     (stat),
        .answer   (answer),
        .status   (status)
    );

    assign m_tdata = {5'b0, status, answer};

    // Each accepted item is worked on alone before the next is taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A result is only written into a free or draining output register.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == pse_pkg::CMD_EMIT) |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending item");

    // A written result is presented on the next cycle.
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == pse_pkg::CMD_EMIT) |=> m_tvalid)
        else $error("result not presented");

endmodule
`default_nettype wire

[design/pse_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pse_dpath
// Stack memory, count and status registers, sequential multiplier and
// restoring divider of the postfix evaluator.
// ----------------------------------------------------------------------------
module pse_dpath #(
    parameter int STACK_DEPTH   = pse_pkg::DEF_STACK_DEPTH,
    parameter int FRACTION_BITS = pse_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire pse_pkg::cmd_t                  cmd,
    input  wire logic [pse_pkg::TOKEN_W-1:0]    in_token,
    output pse_pkg::dp_status_t                 stat,
    output logic [pse_pkg::WORD_W-1:0]          answer,
    output logic [pse_pkg::STATUS_W-1:0]        status
);

    localparam int W     = pse_pkg::WORD_W;
    localparam int PW    = pse_pkg::PROD_W;
    localparam int HW    = pse_pkg::HALF_W;
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int NUM_W = W + FRACTION_BITS;
    localparam int IW    = $clog2(NUM_W);

    localparam logic [PW-1:0] POS_LIM = PW'({1'b0, {(W-1){1'b1}}});
    localparam logic [PW-1:0] NEG_LIM = PW'({1'b1, {(W-1){1'b0}}});

    logic [W-1:0]          mem [STACK_DEPTH];
    logic [W-1:0]          rdata_reg;
    logic [pse_pkg::TOKEN_W-1:0] tok_reg;
    logic [CW-1:0]         count_reg, count_next;
    pse_pkg::status_code_t sticky_reg, sticky_next;
    logic [W-1:0]          a_reg, b_reg;
    logic [W-1:0]          ma_reg, mb_reg;
    logic                  neg_reg;
    logic [PW-1:0]         acc_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [W:0]            rem_reg;
    logic [IW-1:0]         iter_reg;
    logic [W-1:0]          answer_reg;
    logic [pse_pkg::STATUS_W-1:0] status_reg;

    pse_pkg::op_t          op;
    logic [CW-1:0]         cnt_m1, cnt_m2;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [W-1:0]          mem_wdata, push_val, result;
    logic                  result_sat;
    logic [W:0]            sum;
    logic [PW-1:0]         mag, lim;
    logic [HW-1:0]         pa, pb;
    logic [W-1:0]          pp;
    logic [PW-1:0]         part;
    logic [W:0]            rem_sh;
    logic                  q_bit;
    logic                  flag_en;
    pse_pkg::status_code_t flag_code;

    assign op     = pse_pkg::op_of(tok_reg);
    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);

    assign stat.is_end     = (tok_reg == pse_pkg::TOK_END);
    assign stat.is_op      = (tok_reg == pse_pkg::TOK_ADD) || (tok_reg == pse_pkg::TOK_SUB) ||
                             (tok_reg == pse_pkg::TOK_MUL) || (tok_reg == pse_pkg::TOK_DIV);
    assign stat.op         = op;
    assign stat.lt2        = (count_reg < CW'(2));
    assign stat.full       = (count_reg >= CW'(STACK_DEPTH));
    assign stat.count_zero = (count_reg == '0);
    assign stat.b_zero     = (b_reg == '0);
    assign stat.iter_done  = (op == pse_pkg::OP_MUL) ? (iter_reg == IW'(3))
                                                     : (iter_reg == IW'(NUM_W - 1));

    always_comb begin
        if ((tok_reg >= pse_pkg::TOK_ZERO) && (tok_reg <= pse_pkg::TOK_NINE)) begin
            push_val = W'(tok_reg - pse_pkg::TOK_ZERO) << FRACTION_BITS;
        end else begin
            push_val = '0;
        end
    end

    // Operator result, saturated to the signed word range (zero for x/0).
    always_comb begin
        sum = (op == pse_pkg::OP_SUB) ? ({a_reg[W-1], a_reg} - {b_reg[W-1], b_reg})
                                      : ({a_reg[W-1], a_reg} + {b_reg[W-1], b_reg});
        mag = (op == pse_pkg::OP_MUL) ? (acc_reg >> FRACTION_BITS) : PW'(num_reg);
        lim = neg_reg ? NEG_LIM : POS_LIM;
        result     = '0;
        result_sat = 1'b0;
        if ((op == pse_pkg::OP_ADD) || (op == pse_pkg::OP_SUB)) begin
            if (sum[W] != sum[W-1]) begin
                result_sat = 1'b1;
                result     = sum[W] ? NEG_LIM[W-1:0] : POS_LIM[W-1:0];
            end else begin
                result = sum[W-1:0];
            end
        end else if ((op == pse_pkg::OP_DIV) && (mb_reg == '0)) begin
            result = '0;
        end else begin
            if (mag > lim) begin
                result_sat = 1'b1;
                result     = neg_reg ? lim[W-1:0] : POS_LIM[W-1:0];
            end else begin
                result = neg_reg ? (W'(0) - mag[W-1:0]) : mag[W-1:0];
            end
        end
    end

    // One 24x24 partial product per multiply step.
    always_comb begin
        pa = iter_reg[1] ? ma_reg[W-1:HW] : ma_reg[HW-1:0];
        pb = iter_reg[0] ? mb_reg[W-1:HW] : mb_reg[HW-1:0];
        pp = W'(pa) * W'(pb);
        case (iter_reg[1:0])
            2'b00:   part = PW'(pp);
            2'b11:   part = PW'(pp) << (2 * HW);
            default: part = PW'(pp) << HW;
        endcase
    end

    // One quotient bit per divide step.
    always_comb begin
        rem_sh = {rem_reg[W-1:0], num_reg[NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, mb_reg});
    end

    always_comb begin
        mem_we    = (cmd == pse_pkg::CMD_PUSH) || (cmd == pse_pkg::CMD_WRITE);
        mem_waddr = (cmd == pse_pkg::CMD_PUSH) ? count_reg[AW-1:0] : cnt_m2[AW-1:0];
        mem_wdata = (cmd == pse_pkg::CMD_PUSH) ? push_val : result;
        mem_re    = (cmd == pse_pkg::CMD_RD_LOWER) || (cmd == pse_pkg::CMD_RD_TOP) ||
                    (cmd == pse_pkg::CMD_LOAD_A);
        mem_raddr = (cmd == pse_pkg::CMD_RD_LOWER) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
    end

    always_comb begin
        count_next = count_reg;
        flag_en    = 1'b0;
        flag_code  = pse_pkg::ST_OK;
        case (cmd)
            pse_pkg::CMD_PUSH:       count_next = count_reg + CW'(1);
            pse_pkg::CMD_FLAG_UNDER: begin
                flag_en   = 1'b1;
                flag_code = pse_pkg::ST_UNDER;
            end
            pse_pkg::CMD_FLAG_FULL:  begin
                flag_en   = 1'b1;
                flag_code = pse_pkg::ST_FULL;
            end
            pse_pkg::CMD_WRITE:      begin
                count_next = cnt_m1;
                if ((op == pse_pkg::OP_DIV) && (mb_reg == '0)) begin
                    flag_en   = 1'b1;
                    flag_code = pse_pkg::ST_DIV0;
                end else if (result_sat) begin
                    flag_en   = 1'b1;
                    flag_code = pse_pkg::ST_SAT;
                end
            end
            pse_pkg::CMD_EMIT:       count_next = '0;
            default:                 count_next = count_reg;
        endcase
        sticky_next = sticky_reg;
        if (cmd == pse_pkg::CMD_EMIT) begin
            sticky_next = pse_pkg::ST_OK;
        end else if (flag_en && (sticky_reg == pse_pkg::ST_OK)) begin
            sticky_next = flag_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            sticky_reg <= pse_pkg::ST_OK;
        end else begin
            count_reg  <= count_next;
            sticky_reg <= sticky_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            pse_pkg::CMD_LATCH:  tok_reg <= in_token;
            pse_pkg::CMD_LOAD_A: a_reg   <= rdata_reg;
            pse_pkg::CMD_LOAD_B: b_reg   <= rdata_reg;
            pse_pkg::CMD_START:  begin
                ma_reg   <= a_reg[W-1] ? (W'(0) - a_reg) : a_reg;
                mb_reg   <= b_reg[W-1] ? (W'(0) - b_reg) : b_reg;
                neg_reg  <= a_reg[W-1] ^ b_reg[W-1];
                acc_reg  <= '0;
                num_reg  <= NUM_W'(a_reg[W-1] ? (W'(0) - a_reg) : a_reg) << FRACTION_BITS;
                rem_reg  <= '0;
                iter_reg <= '0;
            end
            pse_pkg::CMD_STEP:   begin
                iter_reg <= iter_reg + IW'(1);
                if (op == pse_pkg::OP_MUL) begin
                    acc_reg <= acc_reg + part;
                end else begin
                    rem_reg <= q_bit ? (rem_sh - {1'b0, mb_reg}) : rem_sh;
                    num_reg <= {num_reg[NUM_W-2:0], q_bit};
                end
            end
            pse_pkg::CMD_EMIT:   begin
                answer_reg <= stat.count_zero ? '0 : rdata_reg;
                if (sticky_reg != pse_pkg::ST_OK) begin
                    status_reg <= sticky_reg;
                end else if (stat.count_zero) begin
                    status_reg <= pse_pkg::ST_EMPTY;
                end else begin
                    status_reg <= pse_pkg::ST_OK;
                end
            end
            default: ;
        endcase
    end

    assign answer = answer_reg;
    assign status = status_reg;

endmodule
`default_nettype wire

[design/pse_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pse_ctrl
// Sequencer of the postfix evaluator: decodes each token and steps the
// datapath through stack reads, arithmetic and write-back.
// ----------------------------------------------------------------------------
module pse_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire pse_pkg::dp_status_t  stat,
    output pse_pkg::cmd_t             cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_A,
        S_RD_B,
        S_START,
        S_MUL,
        S_DIV,
        S_WRITE,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = pse_pkg::CMD_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd        = pse_pkg::CMD_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.is_end) begin
                    if (!stat.count_zero) begin
                        cmd = pse_pkg::CMD_RD_TOP;
                    end
                    state_next = S_EMIT;
                end else if (stat.is_op) begin
                    if (stat.lt2) begin
                        cmd        = pse_pkg::CMD_FLAG_UNDER;
                        state_next = S_IDLE;
                    end else begin
                        cmd        = pse_pkg::CMD_RD_LOWER;
                        state_next = S_RD_A;
                    end
                end else begin
                    cmd        = stat.full ? pse_pkg::CMD_FLAG_FULL : pse_pkg::CMD_PUSH;
                    state_next = S_IDLE;
                end
            end
            S_RD_A: begin
                cmd        = pse_pkg::CMD_LOAD_A;
                state_next = S_RD_B;
            end
            S_RD_B: begin
                cmd        = pse_pkg::CMD_LOAD_B;
                state_next = S_START;
            end
            S_START: begin
                cmd = pse_pkg::CMD_START;
                case (stat.op)
                    pse_pkg::OP_MUL: state_next = S_MUL;
                    pse_pkg::OP_DIV: state_next = stat.b_zero ? S_WRITE : S_DIV;
                    default:         state_next = S_WRITE;
                endcase
            end
            S_MUL, S_DIV: begin
                cmd = pse_pkg::CMD_STEP;
                if (stat.iter_done) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd        = pse_pkg::CMD_WRITE;
                state_next = S_IDLE;
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd        = pse_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (cmd == pse_pkg::CMD_EMIT) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule
`default_nettype wire

[dv/postfix_stack_evaluator_core_test.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core_test
// Self-checking bench for the postfix evaluator: token items are streamed in
// under varying idle and stall patterns, and every answer item is compared
// field by field with a fixed-point stack predictor kept in the bench.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core_test;

    localparam int DEPTH = pse_pkg::DEF_STACK_DEPTH;
    localparam int FRAC  = pse_pkg::DEF_FRACTION_BITS;
    localparam longint LIMIT_CYCLES = 4000000;

    typedef struct {
        logic [pse_pkg::WORD_W-1:0] answer;
        pse_pkg::status_code_t      status;
    } answer_t;

    // Predictor plus the queue of answers still owed by the block.
    class answer_scoreboard;
        logic signed [pse_pkg::WORD_W-1:0] stack_mem [DEPTH];
        int unsigned depth_used;
        pse_pkg::status_code_t sticky;
        answer_t owed [$];
        int errors;
        int answers_seen;

        function void flag(pse_pkg::status_code_t c);
            if (sticky == pse_pkg::ST_OK) sticky = c;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        // Clamp a wide signed value into the word range, flagging saturation.
        function logic signed [pse_pkg::WORD_W-1:0] clamp(logic signed [191:0] v);
            logic signed [191:0] hi;
            logic signed [191:0] lo;
            hi = (192'sd1 <<< (pse_pkg::WORD_W - 1)) - 1;
            lo = -(192'sd1 <<< (pse_pkg::WORD_W - 1));
            if (v > hi) begin
                flag(pse_pkg::ST_SAT);
                return hi[pse_pkg::WORD_W-1:0];
            end
            if (v < lo) begin
                flag(pse_pkg::ST_SAT);
                return lo[pse_pkg::WORD_W-1:0];
            end
            return v[pse_pkg::WORD_W-1:0];
        endfunction

        function void note_token(logic [pse_pkg::TOKEN_W-1:0] tok);
            logic signed [191:0] a;
            logic signed [191:0] b;
            logic signed [191:0] r;
            logic [191:0] ma;
            logic [191:0] mb;
            logic [191:0] mq;
            logic neg;
            answer_t ans;
            if (tok == pse_pkg::TOK_END) begin
                ans.answer = '0;
                if (depth_used == 0) flag(pse_pkg::ST_EMPTY);
                else ans.answer = stack_mem[depth_used-1];
                ans.status = sticky;
                owed.push_back(ans);
                depth_used = 0;
                sticky = pse_pkg::ST_OK;
            end else if (tok == pse_pkg::TOK_ADD || tok == pse_pkg::TOK_SUB ||
                         tok == pse_pkg::TOK_MUL || tok == pse_pkg::TOK_DIV) begin
                if (depth_used < 2) begin
                    flag(pse_pkg::ST_UNDER);
                    return;
                end
                a = stack_mem[depth_used-2];
                b = stack_mem[depth_used-1];
                neg = (a < 0) != (b < 0);
                ma = (a < 0) ? -a : a;
                mb = (b < 0) ? -b : b;
                case (tok)
                    pse_pkg::TOK_ADD: r = clamp(a + b);
                    pse_pkg::TOK_SUB: r = clamp(a - b);
                    pse_pkg::TOK_MUL: begin
                        mq = (ma * mb) >> FRAC;
                        r = clamp(neg ? -$signed(mq) : $signed(mq));
                    end
                    default: begin
                        if (mb == 0) begin
                            flag(pse_pkg::ST_DIV0);
                            r = 0;
                        end else begin
                            mq = (ma << FRAC) / mb;
                            r = clamp(neg ? -$signed(mq) : $signed(mq));
                        end
                    end
                endcase
                stack_mem[depth_used-2] = r[pse_pkg::WORD_W-1:0];
                depth_used--;
            end else if (depth_used >= DEPTH) begin
                flag(pse_pkg::ST_FULL);
            end else begin
                if (tok >= pse_pkg::TOK_ZERO && tok <= pse_pkg::TOK_NINE)
                    stack_mem[depth_used] =
                        pse_pkg::WORD_W'(tok - pse_pkg::TOK_ZERO) << FRAC;
                else
                    stack_mem[depth_used] = '0;
                depth_used++;
            end
        endfunction

        task check_answer(logic [55:0] data);
            answer_t exp_ans;
            answers_seen++;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("unexpected answer %h", data));
                return;
            end
            exp_ans = owed.pop_front();
            if (data[pse_pkg::WORD_W-1:0] !== exp_ans.answer)
                report_mismatch($sformatf("answer %h, expected %h",
                                          data[pse_pkg::WORD_W-1:0], exp_ans.answer));
            if (data[50:48] !== exp_ans.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          data[50:48], exp_ans.status));
            if (data[55:51] !== 5'd0)
                report_mismatch($sformatf("pad bits %b not zero", data[55:51]));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    answer_scoreboard board;
    int  mismatches;
    int  sender_idle_pct;
    int  receiver_stall_pct;
    int  hold_off_cycles;
    int  tokens_sent;
    longint cycle_count;

    postfix_stack_evaluator_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Watchdog: ends the run as a failure once the cycle count passes LIMIT_CYCLES.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Both handshakes are sampled at the rising edge; the scoreboard sees
    // every accepted item in order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                board.note_token(s_tdata);
                tokens_sent++;
            end
            if (m_tvalid && m_tready) board.check_answer(m_tdata);
        end
    end

    // Receiver: stalls at random, or holds off entirely for a long stretch.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offer one token and wait for it to be taken; idles first at random.
    // The valid line is left as it is on return, so the next call either
    // idles it or presents the following token at the same falling edge.
    task automatic send_token(logic [7:0] tok);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tok;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_digit();
        return pse_pkg::TOK_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(3))
            0: return pse_pkg::TOK_ADD;
            1: return pse_pkg::TOK_SUB;
            2: return pse_pkg::TOK_MUL;
            default: return pse_pkg::TOK_DIV;
        endcase
    endfunction

    // A mostly well-formed expression: random operand pushes with operators
    // placed so the stack rarely runs dry, and occasional noise bytes.
    task automatic send_expression();
        int live;
        int len;
        int r;
        live = 0;
        len = $urandom_range(1, 14);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(99);
            if (live >= 2 && r < 45) begin
                send_token(rand_op());
                live--;
            end else if (r < 50) begin
                send_token(rand_op());
                if (live >= 2) live--;
            end else if (r < 55) begin
                send_token(8'($urandom_range(1, 255)));
                live++;
            end else begin
                send_token(rand_digit());
                live++;
            end
        end
        while (live > 1 && $urandom_range(3) != 0) begin
            send_token(rand_op());
            live--;
        end
        send_token(pse_pkg::TOK_END);
    endtask

    task automatic directed_tokens();
        // Empty expression, then an operator with nothing beneath it.
        send_token(pse_pkg::TOK_END);
        send_token(pse_pkg::TOK_ADD);
        send_token(pse_pkg::TOK_END);
        // Operand order for subtract and divide: 9 - 2 and 8 / 3.
        send_token("9"); send_token("2"); send_token(pse_pkg::TOK_SUB);
        send_token(pse_pkg::TOK_END);
        send_token("8"); send_token("3"); send_token(pse_pkg::TOK_DIV);
        send_token(pse_pkg::TOK_END);
        // Division by zero, and a non-digit byte pushing zero.
        send_token("5"); send_token(8'hFF); send_token(pse_pkg::TOK_DIV);
        send_token(pse_pkg::TOK_END);
        // Leftover values below the top, then a multiply.
        send_token("7"); send_token("0"); send_token("9"); send_token(pse_pkg::TOK_MUL);
        send_token(pse_pkg::TOK_END);
    endtask

    // Push nine and multiply by nine a few times, then keep multiplying until
    // the result saturates high, negate it by a subtraction from zero and
    // multiply once more into the low limit.
    task automatic saturation_tokens();
        send_token("9");
        for (int k = 0; k < 6; k++) begin
            send_token("9"); send_token(pse_pkg::TOK_MUL);
        end
        send_token(pse_pkg::TOK_END);
        send_token("0"); send_token("9");
        for (int k = 0; k < 14; k++) begin
            send_token("9"); send_token(pse_pkg::TOK_MUL);
        end
        send_token(pse_pkg::TOK_SUB);
        send_token("9"); send_token(pse_pkg::TOK_MUL);
        send_token(pse_pkg::TOK_END);
        // Fill past the stack depth to reach the full case.
        for (int k = 0; k < DEPTH + 2; k++) send_token(rand_digit());
        send_token(pse_pkg::TOK_END);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.owed.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    initial begin
        board = new();
        board.depth_used = 0;
        board.sticky = pse_pkg::ST_OK;
        mismatches = 0;
        tokens_sent = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        directed_tokens();
        saturation_tokens();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
                default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
            endcase
            // In the first phase the receiver shuts off for a long while so
            // that pending answers back up and the input is stalled.
            if (phase == 0) hold_off_cycles = 3000;
            while (tokens_sent < 200 + (phase + 1) * 390) send_expression();
            // Send one random byte, then an end byte to close the expression.
            send_token(8'($urandom_range(255)));
            send_token(pse_pkg::TOK_END);
        end

        drain();
        $display("Covered %0d tokens and %0d answers under four idle patterns,",
                 tokens_sent, board.answers_seen);
        $display("including saturation, underflow, full stack and divide by zero.");
        mismatches += board.errors;
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

[postfix_stack_evaluator_core.f]
design/pse_pkg.sv
design/pse_dpath.sv
design/pse_ctrl.sv
design/postfix_stack_evaluator_core.sv
dv/postfix_stack_evaluator_core_test.sv
